// ===== rtl/cpd_pkg.sv =====
package cpd_pkg;

   // number formats and fixed constants of the physics, Q8.24
   localparam int                 CFG_COUNT      = 8;
   localparam int                 CFG_AW         = 5;
   localparam int                 DEF_TIME_STEP  = 335544;
   localparam int                 DEF_STEP_CAP   = 500;
   localparam logic signed [31:0] Q_MAX          = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN          = 32'sh8000_0000;
   localparam logic signed [31:0] FOUR_THIRDS_Q  = 32'sd22369621;
   localparam logic signed [31:0] PI_Q           = 32'sd52707179;
   localparam logic signed [31:0] TWO_PI_Q       = 32'sd105414357;
   localparam logic signed [31:0] HALF_PI_Q      = 32'sd26353589;
   localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
   localparam logic [4:0]         CORDIC_LAST    = 5'd29;
   localparam logic [9:0]         STEP_SAT       = 10'd1023;

   // register indexes
   localparam logic [2:0] REG_FORCE = 3'd0;
   localparam logic [2:0] REG_GRAV  = 3'd1;
   localparam logic [2:0] REG_LEN   = 3'd2;
   localparam logic [2:0] REG_MP    = 3'd3;
   localparam logic [2:0] REG_MT    = 3'd4;
   localparam logic [2:0] REG_PML   = 3'd5;
   localparam logic [2:0] REG_PLIM  = 3'd6;
   localparam logic [2:0] REG_ALIM  = 3'd7;

   localparam logic [30:0] CFG_RESET [0:CFG_COUNT-1] = '{
      31'd167772160, 31'd164416717, 31'd8388608, 31'd1677722,
      31'd18454938, 31'd838861, 31'd40265318, 31'd3513869
   };

   typedef enum logic [3:0] {
      S_IDLE, S_WRAP, S_FOLD1, S_FOLD2, S_ROT, S_SCALE, S_ISSUE, S_WAIT, S_OUT
   } state_type;

   // micro-program of the step, one shared multiply/divide each
   typedef enum logic [4:0] {
      OP_PML_RATE, OP_RATE2, OP_SN, OP_TEMP, OP_G_SN, OP_CS_TEMP, OP_MP_CS,
      OP_CS2, OP_DIV_MT, OP_DEN, OP_TACC, OP_PML_TACC, OP_TACC_CS, OP_XACC,
      OP_POS, OP_VEL, OP_ANG, OP_RATE_UPD
   } op_type;

   typedef struct packed {
      logic               start;
      logic               is_div;
      logic signed [31:0] opa;
      logic signed [31:0] opb;
   } arith_req_type;

   // cordic arctangent table, 30 fraction bits
   function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h0;
      endcase
      return $signed({1'b0, v});
   endfunction

   // saturating add and subtract on the signed 32-bit range
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
      return s[31:0];
   endfunction

endpackage

// ===== rtl/cpd_ifs.sv =====
interface cpd_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic               push_right;
   logic signed [31:0] init_position;
   logic signed [31:0] init_velocity;
   logic signed [31:0] init_angle;
   logic signed [31:0] init_angular_rate;

   modport source (output valid, req_type, push_right, init_position, init_velocity,
                   init_angle, init_angular_rate, input ready);
   modport sink (input valid, req_type, push_right, init_position, init_velocity,
                 init_angle, init_angular_rate, output ready);
endinterface

interface cpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_out;
   logic signed [31:0] velocity_out;
   logic signed [31:0] angle_out;
   logic signed [31:0] angular_rate_out;
   logic               reward_out;
   logic               done_out;

   modport source (output valid, position_out, velocity_out, angle_out,
                   angular_rate_out, reward_out, done_out, input ready);
   modport sink (input valid, position_out, velocity_out, angle_out,
                 angular_rate_out, reward_out, done_out, output ready);
endinterface

// ===== rtl/cpd_arith.sv =====
// bit-serial multiply (32 iterations) and restoring divide (56 iterations), Q8.24
module cpd_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  cpd_pkg::arith_req_type req,
   output logic                  done,
   output logic signed [31:0]    result
);

   logic               busy_ff, is_div_ff, neg_ff, zdiv_ff, nneg_ff, done_ff;
   logic [5:0]         cnt_ff;
   logic [31:0]        mag_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        rem_ff;
   logic [55:0]        quo_ff;
   logic signed [31:0] res_ff;

   logic [31:0]        mag_a, mag_b;
   logic [32:0]        psum;
   logic [32:0]        trial;
   logic [33:0]        diff;
   logic signed [63:0] sprod, rnd;
   logic signed [39:0] shq;
   logic signed [31:0] fin;

   assign mag_a = req.opa[31] ? 32'(-req.opa) : 32'(req.opa);
   assign mag_b = req.opb[31] ? 32'(-req.opb) : 32'(req.opb);

   // one partial product or one quotient bit a cycle
   assign psum  = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, mag_ff} : 33'd0);
   assign trial = {rem_ff, quo_ff[55]};
   assign diff  = {1'b0, trial} - {2'b00, mag_ff};

   // rounding, sign and saturation of the finished word
   always_comb begin
      sprod = neg_ff ? -$signed(prod_ff) : $signed(prod_ff);
      rnd   = sprod + 64'sd8388608;
      shq   = rnd[63:24];
      fin   = '0;
      if (!is_div_ff) begin
         if (shq[39:31] == '0 || shq[39:31] == '1) fin = shq[31:0];
         else fin = shq[39] ? cpd_pkg::Q_MIN : cpd_pkg::Q_MAX;
      end else if (zdiv_ff) begin
         fin = nneg_ff ? cpd_pkg::Q_MIN : cpd_pkg::Q_MAX;
      end else if (neg_ff) begin
         if (quo_ff > 56'h80000000) fin = cpd_pkg::Q_MIN;
         else fin = -$signed(quo_ff[31:0]);
      end else begin
         if (quo_ff > 56'h7FFFFFFF) fin = cpd_pkg::Q_MAX;
         else fin = $signed(quo_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff   <= 1'b1;
            is_div_ff <= req.is_div;
            neg_ff    <= req.opa[31] ^ req.opb[31];
            nneg_ff   <= req.opa[31];
            zdiv_ff   <= (req.opb == '0);
            if (req.is_div) begin
               mag_ff <= mag_b;
               quo_ff <= {mag_a, 24'd0};
               rem_ff <= '0;
               cnt_ff <= 6'd56;
            end else begin
               mag_ff  <= mag_a;
               prod_ff <= {32'd0, mag_b};
               cnt_ff  <= 6'd32;
            end
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               res_ff  <= fin;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
               if (is_div_ff) begin
                  if (!diff[33]) begin
                     rem_ff <= diff[31:0];
                     quo_ff <= {quo_ff[54:0], 1'b1};
                  end else begin
                     rem_ff <= trial[31:0];
                     quo_ff <= {quo_ff[54:0], 1'b0};
                  end
               end else begin
                  prod_ff <= {psum, prod_ff[31:1]};
               end
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== rtl/cart_pole_dynamics_step.sv =====
// Cart-pole physics step in signed Q8.24.
// req channel: a word with req_type 0 loads the four state values and clears
// the step count; req_type 1 pushes the cart left or right and advances the
// state by one Euler step. Every word gives exactly one rsp word with the new
// state, done and reward.
// A step runs the angle reduction, 30 CORDIC iterations, then 14 multiplies
// and 4 divides on one shared bit-serial unit; one word is in work at a time.
// The csr port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds
// eight 31-bit registers at byte addresses 4*i; pready is always high.
// Reset clears the state and step count and restores the register defaults.
// The result sits in an output register: if the receiver stalls, the next
// word is still taken and its result waits until the first one is taken.
module cart_pole_dynamics_step #(
   parameter int TIME_STEP_Q = cpd_pkg::DEF_TIME_STEP,
   parameter int STEP_CAP    = cpd_pkg::DEF_STEP_CAP
) (
   input  logic                      clock,
   input  logic                      reset,
   cpd_req_if.sink                   req,
   cpd_rsp_if.source                 rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [cpd_pkg::CFG_AW-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   // configuration registers
   logic [30:0] cfg_ff [0:cpd_pkg::CFG_COUNT-1];
   logic [2:0]  cfg_idx;

   assign cfg_idx = paddr[4:2];
   assign pready  = 1'b1;
   assign prdata  = {1'b0, cfg_ff[cfg_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cpd_pkg::CFG_COUNT; i++) cfg_ff[i] <= cpd_pkg::CFG_RESET[i];
      end else if (psel && penable && pwrite) begin
         cfg_ff[cfg_idx] <= pwdata[30:0];
      end
   end

   logic signed [31:0] fm, g, len, mp, mt, pml;
   assign fm  = $signed({1'b0, cfg_ff[cpd_pkg::REG_FORCE]});
   assign g   = $signed({1'b0, cfg_ff[cpd_pkg::REG_GRAV]});
   assign len = $signed({1'b0, cfg_ff[cpd_pkg::REG_LEN]});
   assign mp  = $signed({1'b0, cfg_ff[cpd_pkg::REG_MP]});
   assign mt  = $signed({1'b0, cfg_ff[cpd_pkg::REG_MT]});
   assign pml = $signed({1'b0, cfg_ff[cpd_pkg::REG_PML]});

   // control and datapath registers
   cpd_pkg::state_type state_ff, state_in;
   cpd_pkg::op_type    op_ff, op_in;
   logic               kind_ff, kind_in, push_ff, push_in, neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         steps_ff, steps_in;
   logic [4:0]         it_ff, it_in;
   logic signed [31:0] pos_ff, pos_in, vel_ff, vel_in, ang_ff, ang_in, rate_ff, rate_in;
   logic signed [31:0] r_ff, r_in, sn_ff, sn_in, cs_ff, cs_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic signed [31:0] t_ff, t_in, temp_ff, temp_in, num_ff, num_in;
   logic signed [31:0] tacc_ff, tacc_in, xacc_ff, xacc_in;
   logic signed [31:0] o_pos_ff, o_pos_in, o_vel_ff, o_vel_in;
   logic signed [31:0] o_ang_ff, o_ang_in, o_rate_ff, o_rate_in;
   logic               o_rew_ff, o_rew_in, o_done_ff, o_done_in;

   cpd_pkg::arith_req_type arq;
   logic                   ar_done;
   logic signed [31:0]     ar_res;

   cpd_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (arq),
      .done  (ar_done),
      .result(ar_res)
   );

   // helpers for the sequencer
   logic signed [31:0] force_q, ts_q, rr;
   logic signed [33:0] dx, dy, xs, ys;
   logic [31:0]        apos, aang;
   logic               done_flag;

   assign force_q = push_ff ? fm : -fm;
   assign ts_q    = 32'(TIME_STEP_Q);
   assign dx      = y_ff >>> it_ff;
   assign dy      = x_ff >>> it_ff;
   assign xs      = (x_ff + 34'sd32) >>> 6;
   assign ys      = (y_ff + 34'sd32) >>> 6;
   assign apos    = pos_ff[31] ? 32'(-pos_ff) : 32'(pos_ff);
   assign aang    = ang_ff[31] ? 32'(-ang_ff) : 32'(ang_ff);
   assign done_flag = (apos > {1'b0, cfg_ff[cpd_pkg::REG_PLIM]})
                   || (aang > {1'b0, cfg_ff[cpd_pkg::REG_ALIM]})
                   || (steps_ff >= 10'(STEP_CAP));

   // half-pi fold of the wrapped angle
   always_comb begin
      rr = r_ff;
      if (r_ff > cpd_pkg::HALF_PI_Q) rr = r_ff - cpd_pkg::PI_Q;
      else if (r_ff < -cpd_pkg::HALF_PI_Q) rr = r_ff + cpd_pkg::PI_Q;
   end

   // next state and outputs
   always_comb begin
      state_in = state_ff;  op_in = op_ff;  kind_in = kind_ff;  push_in = push_ff;
      neg_in = neg_ff;  steps_in = steps_ff;  it_in = it_ff;
      pos_in = pos_ff;  vel_in = vel_ff;  ang_in = ang_ff;  rate_in = rate_ff;
      r_in = r_ff;  sn_in = sn_ff;  cs_in = cs_ff;  x_in = x_ff;  y_in = y_ff;
      z_in = z_ff;  t_in = t_ff;  temp_in = temp_ff;  num_in = num_ff;
      tacc_in = tacc_ff;  xacc_in = xacc_ff;
      o_pos_in = o_pos_ff;  o_vel_in = o_vel_ff;  o_ang_in = o_ang_ff;
      o_rate_in = o_rate_ff;  o_rew_in = o_rew_ff;  o_done_in = o_done_ff;
      rsp_valid_in = rsp_valid_ff;
      arq = '0;

      // result word taken
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         cpd_pkg::S_IDLE: begin
            if (req.valid) begin
               kind_in = req.req_type;
               push_in = req.push_right;
               if (!req.req_type) begin
                  pos_in   = req.init_position;
                  vel_in   = req.init_velocity;
                  ang_in   = req.init_angle;
                  rate_in  = req.init_angular_rate;
                  steps_in = '0;
                  state_in = cpd_pkg::S_OUT;
               end else begin
                  r_in     = ang_ff;
                  state_in = cpd_pkg::S_WRAP;
               end
            end
         end
         // remainder by two pi, one subtraction or addition a cycle
         cpd_pkg::S_WRAP: begin
            if (r_ff >= cpd_pkg::TWO_PI_Q) r_in = r_ff - cpd_pkg::TWO_PI_Q;
            else if (r_ff <= -cpd_pkg::TWO_PI_Q) r_in = r_ff + cpd_pkg::TWO_PI_Q;
            else state_in = cpd_pkg::S_FOLD1;
         end
         cpd_pkg::S_FOLD1: begin
            if (r_ff > cpd_pkg::PI_Q) r_in = r_ff - cpd_pkg::TWO_PI_Q;
            else if (r_ff < -cpd_pkg::PI_Q) r_in = r_ff + cpd_pkg::TWO_PI_Q;
            state_in = cpd_pkg::S_FOLD2;
         end
         cpd_pkg::S_FOLD2: begin
            neg_in   = (r_ff > cpd_pkg::HALF_PI_Q) || (r_ff < -cpd_pkg::HALF_PI_Q);
            z_in     = $signed({rr[25], rr[25:0], 6'd0});
            x_in     = cpd_pkg::CORDIC_GAIN;
            y_in     = '0;
            it_in    = '0;
            state_in = cpd_pkg::S_ROT;
         end
         // one cordic rotation a cycle
         cpd_pkg::S_ROT: begin
            if (!z_ff[32]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - cpd_pkg::atan_q30(it_ff);
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + cpd_pkg::atan_q30(it_ff);
            end
            it_in = it_ff + 5'd1;
            if (it_ff == cpd_pkg::CORDIC_LAST) state_in = cpd_pkg::S_SCALE;
         end
         cpd_pkg::S_SCALE: begin
            cs_in    = neg_ff ? -xs[31:0] : xs[31:0];
            sn_in    = neg_ff ? -ys[31:0] : ys[31:0];
            op_in    = cpd_pkg::OP_PML_RATE;
            state_in = cpd_pkg::S_ISSUE;
         end
         // operands of the current step to the shared unit
         cpd_pkg::S_ISSUE: begin
            arq.start = 1'b1;
            case (op_ff)
               cpd_pkg::OP_PML_RATE: begin arq.opa = pml;    arq.opb = rate_ff; end
               cpd_pkg::OP_RATE2:    begin arq.opa = t_ff;   arq.opb = rate_ff; end
               cpd_pkg::OP_SN:       begin arq.opa = t_ff;   arq.opb = sn_ff;   end
               cpd_pkg::OP_TEMP: begin
                  arq.is_div = 1'b1;
                  arq.opa    = cpd_pkg::sat_add(force_q, t_ff);
                  arq.opb    = mt;
               end
               cpd_pkg::OP_G_SN:     begin arq.opa = g;      arq.opb = sn_ff;   end
               cpd_pkg::OP_CS_TEMP:  begin arq.opa = cs_ff;  arq.opb = temp_ff; end
               cpd_pkg::OP_MP_CS:    begin arq.opa = mp;     arq.opb = cs_ff;   end
               cpd_pkg::OP_CS2:      begin arq.opa = t_ff;   arq.opb = cs_ff;   end
               cpd_pkg::OP_DIV_MT: begin
                  arq.is_div = 1'b1;  arq.opa = t_ff;  arq.opb = mt;
               end
               cpd_pkg::OP_DEN: begin
                  arq.opa = len;
                  arq.opb = cpd_pkg::sat_sub(cpd_pkg::FOUR_THIRDS_Q, t_ff);
               end
               cpd_pkg::OP_TACC: begin
                  arq.is_div = 1'b1;  arq.opa = num_ff;  arq.opb = t_ff;
               end
               cpd_pkg::OP_PML_TACC: begin arq.opa = pml;  arq.opb = tacc_ff; end
               cpd_pkg::OP_TACC_CS:  begin arq.opa = t_ff; arq.opb = cs_ff;   end
               cpd_pkg::OP_XACC: begin
                  arq.is_div = 1'b1;  arq.opa = t_ff;  arq.opb = mt;
               end
               cpd_pkg::OP_POS:      begin arq.opa = ts_q; arq.opb = vel_ff;  end
               cpd_pkg::OP_VEL:      begin arq.opa = ts_q; arq.opb = xacc_ff; end
               cpd_pkg::OP_ANG:      begin arq.opa = ts_q; arq.opb = rate_ff; end
               cpd_pkg::OP_RATE_UPD: begin arq.opa = ts_q; arq.opb = tacc_ff; end
               default: ;
            endcase
            state_in = cpd_pkg::S_WAIT;
         end
         // write back the finished product or quotient
         cpd_pkg::S_WAIT: begin
            if (ar_done) begin
               op_in    = cpd_pkg::op_type'(5'(op_ff) + 5'd1);
               state_in = cpd_pkg::S_ISSUE;
               case (op_ff)
                  cpd_pkg::OP_TEMP:     temp_in = ar_res;
                  cpd_pkg::OP_G_SN:     num_in  = ar_res;
                  cpd_pkg::OP_CS_TEMP:  num_in  = cpd_pkg::sat_sub(num_ff, ar_res);
                  cpd_pkg::OP_TACC:     tacc_in = ar_res;
                  cpd_pkg::OP_XACC:     xacc_in = cpd_pkg::sat_sub(temp_ff, ar_res);
                  cpd_pkg::OP_POS:      pos_in  = cpd_pkg::sat_add(pos_ff, ar_res);
                  cpd_pkg::OP_VEL:      vel_in  = cpd_pkg::sat_add(vel_ff, ar_res);
                  cpd_pkg::OP_ANG:      ang_in  = cpd_pkg::sat_add(ang_ff, ar_res);
                  cpd_pkg::OP_RATE_UPD: begin
                     rate_in  = cpd_pkg::sat_add(rate_ff, ar_res);
                     if (steps_ff != cpd_pkg::STEP_SAT) steps_in = steps_ff + 10'd1;
                     state_in = cpd_pkg::S_OUT;
                  end
                  default:              t_in    = ar_res;
               endcase
            end
         end
         // load the output register once it is free
         cpd_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               o_pos_in     = pos_ff;
               o_vel_in     = vel_ff;
               o_ang_in     = ang_ff;
               o_rate_in    = rate_ff;
               o_done_in    = kind_ff & done_flag;
               o_rew_in     = kind_ff & !done_flag;
               rsp_valid_in = 1'b1;
               state_in     = cpd_pkg::S_IDLE;
            end
         end
         default: state_in = cpd_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpd_pkg::S_IDLE;
         op_ff        <= cpd_pkg::OP_PML_RATE;
         rsp_valid_ff <= 1'b0;
         steps_ff     <= '0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         ang_ff       <= '0;
         rate_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         steps_ff     <= steps_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         ang_ff       <= ang_in;
         rate_ff      <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;  push_ff <= push_in;  neg_ff <= neg_in;  it_ff <= it_in;
      r_ff <= r_in;  sn_ff <= sn_in;  cs_ff <= cs_in;
      x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;
      t_ff <= t_in;  temp_ff <= temp_in;  num_ff <= num_in;
      tacc_ff <= tacc_in;  xacc_ff <= xacc_in;
      o_pos_ff <= o_pos_in;  o_vel_ff <= o_vel_in;  o_ang_ff <= o_ang_in;
      o_rate_ff <= o_rate_in;  o_rew_ff <= o_rew_in;  o_done_ff <= o_done_in;
   end

   assign req.ready            = (state_ff == cpd_pkg::S_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.position_out     = o_pos_ff;
   assign rsp.velocity_out     = o_vel_ff;
   assign rsp.angle_out        = o_ang_ff;
   assign rsp.angular_rate_out = o_rate_ff;
   assign rsp.reward_out       = o_rew_ff;
   assign rsp.done_out         = o_done_ff;

endmodule
